// File: src/scc_bank_mapper_flash_select_macros.svh
// Assertion helpers shared by the mapper RTL.
`ifndef SCC_BANK_MAPPER_FLASH_SELECT_MACROS_SVH
`define SCC_BANK_MAPPER_FLASH_SELECT_MACROS_SVH

// Clocked check, quiet while reset is asserted.
`define SBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define SBM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: src/sbm_pkg.sv
package sbm_pkg;

    localparam int OP_W       = 2;
    localparam int ADDR_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int ACTION_W   = 3;
    localparam int FADDR_W    = 23;
    localparam int NIB_W      = 4;
    localparam int BLOCK_W    = 2;
    localparam int NUM_BANKS  = 4;
    localparam int PAGE_W     = 2;
    localparam int OFFS_W     = 13;

    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 48;
    localparam int M_TUSER_W  = 3;

    typedef enum logic [OP_W-1:0] {
        OP_MEM_READ  = 2'd0,
        OP_MEM_WRITE = 2'd1,
        OP_IO_WRITE  = 2'd2,
        OP_RSVD      = 2'd3
    } t_op;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE        = 3'd0,
        ACT_UNMAPPED    = 3'd1,
        ACT_FLASH_READ  = 3'd2,
        ACT_FLASH_WRITE = 3'd3,
        ACT_SCC_READ    = 3'd4,
        ACT_SCC_WRITE   = 3'd5,
        ACT_PSG_WRITE   = 3'd6
    } t_action;

    localparam logic [BYTE_W-1:0] PORT_PSG_INDEX = 8'h10;
    localparam logic [BYTE_W-1:0] PORT_PSG_DATA  = 8'h11;
    localparam logic [BYTE_W-1:0] PORT_BLOCK     = 8'h13;

    localparam logic [ADDR_W-1:0] WIN_LO         = 16'h4000;
    localparam logic [ADDR_W-1:0] WIN_HI         = 16'hBFFF;
    localparam logic [ADDR_W-1:0] SCC_LO         = 16'h9800;
    localparam logic [ADDR_W-1:0] SCC_END        = 16'h9FFE;
    localparam logic [ADDR_W-1:0] SCCP_LO        = 16'hB800;
    localparam logic [ADDR_W-1:0] SCCP_END       = 16'hBFFE;
    localparam logic [ADDR_W-1:0] WE_REG_ADDR    = 16'h7FFF;
    localparam logic [ADDR_W-1:0] BANK_REG_MASK  = 16'h1800;
    localparam logic [ADDR_W-1:0] BANK_REG_MATCH = 16'h1000;
    localparam logic [ADDR_W-1:0] MODE_REG_MASK  = 16'hFFFE;
    localparam logic [ADDR_W-1:0] MODE_REG_MATCH = 16'hBFFE;
    localparam logic [BYTE_W-1:0] WE_KEY         = 8'h50;
    localparam logic [5:0]        SCC_BANK_KEY   = 6'h3F;
    localparam logic [BYTE_W-1:0] UNMAPPED_DATA  = 8'hFF;

    localparam int MODE_SCC_OFF_BIT = 4;
    localparam int MODE_PLUS_BIT    = 5;
    localparam int ADDR_SCC_GAP_BIT = 8;
    localparam int BANK_PLUS_BIT    = 7;

    typedef struct packed {
        logic [NUM_BANKS-1:0][BYTE_W-1:0] bank;
        logic [BLOCK_W-1:0]               block;
        logic [BYTE_W-1:0]                mode;
        logic                             flash_we;
        logic [NIB_W-1:0]                 psg_idx;
    } t_state;

    typedef struct packed {
        logic               bank_we;
        logic [PAGE_W-1:0]  bank_idx;
        logic               mode_we;
        logic               fwe_we;
        logic               fwe_val;
        logic               psg_we;
        logic               block_we;
        logic [BYTE_W-1:0]  data;
    } t_update;

    typedef struct packed {
        t_action            action;
        logic [FADDR_W-1:0] flash_address;
        logic [BYTE_W-1:0]  scc_offset;
        logic [NIB_W-1:0]   psg_register;
        logic [BYTE_W-1:0]  data_out;
        logic               scc_plus_mode;
    } t_result;

endpackage

// File: src/sbm_state.sv
module sbm_state (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  sbm_pkg::t_update i_upd,
    output sbm_pkg::t_state  o_state
);

    sbm_pkg::t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sbm_pkg::NUM_BANKS; i++) begin
                r_state.bank[i] <= sbm_pkg::BYTE_W'(i);
            end
            r_state.block    <= '0;
            r_state.mode     <= '0;
            r_state.flash_we <= 1'b0;
            r_state.psg_idx  <= '0;
        end else if (i_en) begin
            if (i_upd.bank_we) begin
                r_state.bank[i_upd.bank_idx] <= i_upd.data;
            end
            if (i_upd.mode_we) begin
                r_state.mode <= i_upd.data;
            end
            if (i_upd.fwe_we) begin
                r_state.flash_we <= i_upd.fwe_val;
            end
            if (i_upd.psg_we) begin
                r_state.psg_idx <= i_upd.data[sbm_pkg::NIB_W-1:0];
            end
            if (i_upd.block_we) begin
                r_state.block <= i_upd.data[sbm_pkg::BLOCK_W-1:0];
            end
        end
    end

    assign o_state = r_state;

endmodule

// File: src/sbm_decode.sv
module sbm_decode (
    input  sbm_pkg::t_op                     i_op,
    input  logic [sbm_pkg::ADDR_W-1:0]       i_addr,
    input  logic [sbm_pkg::BYTE_W-1:0]       i_data,
    input  sbm_pkg::t_state                  i_state,
    output sbm_pkg::t_result                 o_result,
    output sbm_pkg::t_update                 o_upd
);

    logic                         is_scc;
    logic                         scc_std;
    logic                         scc_plus;
    logic                         in_window;
    logic [sbm_pkg::PAGE_W-1:0]   page;
    logic [sbm_pkg::FADDR_W-1:0]  faddr;
    logic                         fwe_next;
    logic [sbm_pkg::BYTE_W-1:0]   port;

    always_comb begin
        scc_plus  = i_state.bank[3][sbm_pkg::BANK_PLUS_BIT]
                    && (i_addr >= sbm_pkg::SCCP_LO) && (i_addr < sbm_pkg::SCCP_END);
        scc_std   = (i_state.bank[2][5:0] == sbm_pkg::SCC_BANK_KEY)
                    && (i_addr >= sbm_pkg::SCC_LO) && (i_addr < sbm_pkg::SCC_END);
        is_scc    = !i_state.mode[sbm_pkg::MODE_SCC_OFF_BIT]
                    && !i_addr[sbm_pkg::ADDR_SCC_GAP_BIT]
                    && (i_state.mode[sbm_pkg::MODE_PLUS_BIT] ? scc_plus : scc_std);
        in_window = (i_addr >= sbm_pkg::WIN_LO) && (i_addr <= sbm_pkg::WIN_HI);
        page      = {~i_addr[14], i_addr[13]};
        faddr     = {i_state.block, i_state.bank[page], i_addr[sbm_pkg::OFFS_W-1:0]};
        fwe_next  = (i_addr == sbm_pkg::WE_REG_ADDR) ? (i_data == sbm_pkg::WE_KEY)
                                                     : i_state.flash_we;
        port      = i_addr[sbm_pkg::BYTE_W-1:0];

        o_result               = '0;
        o_result.action        = sbm_pkg::ACT_NONE;
        o_upd                  = '0;
        o_upd.bank_idx         = page;
        o_upd.data             = i_data;
        o_upd.fwe_val          = fwe_next;

        unique case (i_op)
            sbm_pkg::OP_MEM_READ: begin
                if (is_scc) begin
                    o_result.action     = sbm_pkg::ACT_SCC_READ;
                    o_result.scc_offset = port;
                end else if (in_window) begin
                    o_result.action        = sbm_pkg::ACT_FLASH_READ;
                    o_result.flash_address = faddr;
                end else begin
                    o_result.action   = sbm_pkg::ACT_UNMAPPED;
                    o_result.data_out = sbm_pkg::UNMAPPED_DATA;
                end
            end
            sbm_pkg::OP_MEM_WRITE: begin
                if (in_window) begin
                    if (is_scc) begin
                        o_result.action     = sbm_pkg::ACT_SCC_WRITE;
                        o_result.scc_offset = port;
                        o_result.data_out   = i_data;
                    end else begin
                        o_upd.fwe_we = (i_addr == sbm_pkg::WE_REG_ADDR);
                        if (!fwe_next) begin
                            o_upd.bank_we = ((i_addr & sbm_pkg::BANK_REG_MASK)
                                             == sbm_pkg::BANK_REG_MATCH);
                            o_upd.mode_we = ((i_addr & sbm_pkg::MODE_REG_MASK)
                                             == sbm_pkg::MODE_REG_MATCH);
                        end else begin
                            o_result.action        = sbm_pkg::ACT_FLASH_WRITE;
                            o_result.flash_address = faddr;
                            o_result.data_out      = i_data;
                        end
                    end
                end
            end
            sbm_pkg::OP_IO_WRITE: begin
                unique case (port)
                    sbm_pkg::PORT_PSG_INDEX: o_upd.psg_we = 1'b1;
                    sbm_pkg::PORT_PSG_DATA: begin
                        o_result.action       = sbm_pkg::ACT_PSG_WRITE;
                        o_result.psg_register = i_state.psg_idx;
                        o_result.data_out     = i_data;
                    end
                    sbm_pkg::PORT_BLOCK: o_upd.block_we = 1'b1;
                    default: ;
                endcase
            end
            default: ;
        endcase

        o_result.scc_plus_mode = o_upd.mode_we ? i_data[sbm_pkg::MODE_PLUS_BIT]
                                               : i_state.mode[sbm_pkg::MODE_PLUS_BIT];
    end

endmodule

// File: src/scc_bank_mapper_flash_select.sv
// Bank mapper and access router for a flash cartridge. Each input beat is one bus
// access (tuser: operation; tdata: address, write data); each access yields exactly
// one output beat with the routing decision (tuser: action; tdata: flash address,
// SCC offset, PSG register, data out, plus-mode flag). Throughput is one access per
// cycle while m_axis_tready keeps the output from stalling. The access sits in the
// input register while decode and the mapper register update run, then lands in
// the result register. Mapper registers change as each access moves into the
// result register, so back-to-back accesses see the effect of earlier ones.
`include "scc_bank_mapper_flash_select_macros.svh"

module scc_bank_mapper_flash_select (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // address[15:0], write_data[23:16]
    input  logic [sbm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // operation[1:0]
    input  logic [sbm_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // flash_address[22:0], scc_offset[30:23], psg_register[34:31],
    // data_out[42:35], scc_plus_mode[43], zero[47:44]
    output logic [sbm_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // action[2:0]
    output logic [sbm_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

    logic                             r_in_valid;
    sbm_pkg::t_op                     r_op;
    logic [sbm_pkg::ADDR_W-1:0]       r_addr;
    logic [sbm_pkg::BYTE_W-1:0]       r_data;
    logic                             r_out_valid;
    sbm_pkg::t_result                 r_result;

    logic                             n_in_valid;
    logic                             n_out_valid;
    logic                             s_accept;
    logic                             advance;
    sbm_pkg::t_state                  state;
    sbm_pkg::t_result                 result;
    sbm_pkg::t_update                 upd;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_in_valid  = s_accept ? 1'b1 : (advance ? 1'b0 : r_in_valid);
        n_out_valid = advance ? 1'b1 : (m_axis_tready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // hold input beat until it moves on
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op   <= sbm_pkg::t_op'(s_axis_tuser);
            r_addr <= s_axis_tdata[sbm_pkg::ADDR_W-1:0];
            r_data <= s_axis_tdata[sbm_pkg::ADDR_W +: sbm_pkg::BYTE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= result;
        end
    end

    sbm_decode u_decode (
        .i_op     (r_op),
        .i_addr   (r_addr),
        .i_data   (r_data),
        .i_state  (state),
        .o_result (result),
        .o_upd    (upd)
    );

    sbm_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_upd   (upd),
        .o_state (state)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_result.action;
    assign m_axis_tdata  = {4'b0000,
                            r_result.scc_plus_mode,
                            r_result.data_out,
                            r_result.psg_register,
                            r_result.scc_offset,
                            r_result.flash_address};

    `SBM_ASSERT_RST(a_out_empty_after_reset, $past(!i_rst_n) |-> !r_out_valid, "output valid after reset")
    `SBM_ASSERT(a_ready_when_empty, !r_out_valid |-> s_axis_tready, "input stalled with empty output")
    `SBM_ASSERT(a_unmapped_ff, (r_out_valid && r_result.action == sbm_pkg::ACT_UNMAPPED) |-> (r_result.data_out == sbm_pkg::UNMAPPED_DATA), "unmapped read without 0xFF")
    `SBM_ASSERT(a_faddr_only_flash, (r_out_valid && r_result.action != sbm_pkg::ACT_FLASH_READ && r_result.action != sbm_pkg::ACT_FLASH_WRITE) |-> (r_result.flash_address == '0), "flash address on non-flash action")
    `SBM_ASSERT(a_state_moves_with_beat, !advance |=> $stable(state), "mapper state changed without a beat")

endmodule

// File: verif/tb_scc_bank_mapper_flash_select.sv
`timescale 1ns / 1ps

module tb_scc_bank_mapper_flash_select;
    import sbm_pkg::*;

    localparam int RANDOM_ACCESSES = 640;
    localparam int DRAIN_AT        = 300;
    localparam int LONG_HOLD_AT    = 150;
    localparam int LONG_HOLD_LEN   = 300;
    localparam int CYCLE_LIMIT     = 200000;

    typedef struct {
        t_op               op;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        bit                drain_first;
    } bus_access_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [S_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [M_TUSER_W-1:0]  m_axis_tuser;

    scc_bank_mapper_flash_select uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bus_access_t access_q[$];
    t_result     route_q[$];
    bus_access_t cur;

    logic [BYTE_W-1:0]  bank_reg [NUM_BANKS];
    logic [BLOCK_W-1:0] block_reg;
    logic [BYTE_W-1:0]  mode_reg;
    logic               flash_we;
    logic [NIB_W-1:0]   psg_latch;

    int beats_in;
    int beats_out;
    int errors;
    int src_gap;
    int snk_gap;
    int hold_left;
    bit long_hold_done;
    int cycle_cnt;
    int act_seen [8];

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit idle_on();
        return access_q.size() > 100;
    endfunction

    function automatic t_result route_access(input t_op op, input logic [ADDR_W-1:0] addr,
                                             input logic [BYTE_W-1:0] wdata);
        t_result            r;
        logic [PAGE_W-1:0]  pg;
        logic [FADDR_W-1:0] fa;
        logic               in_win;
        logic               scc_hit;
        r = '0;
        r.action = ACT_NONE;
        pg = addr[OFFS_W+PAGE_W-1:OFFS_W] - 2'd2;
        fa = {block_reg, bank_reg[pg], addr[OFFS_W-1:0]};
        in_win = addr >= WIN_LO && addr <= WIN_HI;
        scc_hit = !mode_reg[MODE_SCC_OFF_BIT] && !addr[ADDR_SCC_GAP_BIT] &&
                  (mode_reg[MODE_PLUS_BIT] ?
                   (bank_reg[3][BANK_PLUS_BIT] && addr >= SCCP_LO && addr < SCCP_END) :
                   (bank_reg[2][5:0] == SCC_BANK_KEY && addr >= SCC_LO && addr < SCC_END));
        case (op)
            OP_MEM_READ: begin
                if (scc_hit) begin
                    r.action = ACT_SCC_READ;
                    r.scc_offset = addr[BYTE_W-1:0];
                end else if (in_win) begin
                    r.action = ACT_FLASH_READ;
                    r.flash_address = fa;
                end else begin
                    r.action = ACT_UNMAPPED;
                    r.data_out = UNMAPPED_DATA;
                end
            end
            OP_MEM_WRITE: begin
                if (in_win && scc_hit) begin
                    r.action = ACT_SCC_WRITE;
                    r.scc_offset = addr[BYTE_W-1:0];
                    r.data_out = wdata;
                end else if (in_win) begin
                    if (addr == WE_REG_ADDR) flash_we = (wdata == WE_KEY);
                    if (!flash_we) begin
                        if ((addr & BANK_REG_MASK) == BANK_REG_MATCH) bank_reg[pg] = wdata;
                        if ((addr & MODE_REG_MASK) == MODE_REG_MATCH) mode_reg = wdata;
                    end else begin
                        r.action = ACT_FLASH_WRITE;
                        r.flash_address = fa;
                        r.data_out = wdata;
                    end
                end
            end
            OP_IO_WRITE: begin
                if (addr[BYTE_W-1:0] == PORT_PSG_INDEX) begin
                    psg_latch = wdata[NIB_W-1:0];
                end else if (addr[BYTE_W-1:0] == PORT_PSG_DATA) begin
                    r.action = ACT_PSG_WRITE;
                    r.psg_register = psg_latch;
                    r.data_out = wdata;
                end else if (addr[BYTE_W-1:0] == PORT_BLOCK) begin
                    block_reg = wdata[BLOCK_W-1:0];
                end
            end
            default: ;
        endcase
        r.scc_plus_mode = mode_reg[MODE_PLUS_BIT];
        return r;
    endfunction

    task automatic add_access(input t_op op, input logic [ADDR_W-1:0] addr,
                              input logic [BYTE_W-1:0] data);
        bus_access_t a;
        a.op = op;
        a.addr = addr;
        a.data = data;
        a.drain_first = 1'b0;
        access_q.push_back(a);
    endtask

    function automatic bus_access_t random_access();
        bus_access_t a;
        int          pick;
        a.drain_first = 1'b0;
        a.op = OP_MEM_WRITE;
        a.addr = ADDR_W'($urandom);
        a.data = BYTE_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            a.addr = {3'($urandom_range(2, 5)), 2'b10, 11'($urandom)};
            if ($urandom_range(0, 1)) a.data = a.data | 8'hBF;
        end else if (pick < 14) begin
            a.addr = MODE_REG_MATCH | 16'($urandom_range(0, 1));
            if ($urandom_range(0, 3) != 0) a.data[MODE_SCC_OFF_BIT] = 1'b0;
        end else if (pick < 19) begin
            a.addr = WE_REG_ADDR;
            if ($urandom_range(0, 4) < 2) a.data = WE_KEY;
        end else if (pick < 27) begin
            a.op = OP_IO_WRITE;
            case ($urandom_range(0, 3))
                0: a.addr[BYTE_W-1:0] = PORT_PSG_INDEX;
                1: a.addr[BYTE_W-1:0] = PORT_PSG_DATA;
                2: a.addr[BYTE_W-1:0] = PORT_BLOCK;
                default: ;
            endcase
        end else if (pick < 50) begin
            a.op = $urandom_range(0, 1) ? OP_MEM_READ : OP_MEM_WRITE;
            a.addr = ($urandom_range(0, 1) ? SCC_LO : SCCP_LO) + 16'($urandom_range(0, 2047));
        end else if (pick < 85) begin
            a.op = $urandom_range(0, 1) ? OP_MEM_READ : OP_MEM_WRITE;
            a.addr = ADDR_W'($urandom_range(WIN_LO, WIN_HI));
        end else begin
            a.op = t_op'($urandom_range(0, 3));
        end
        return a;
    endfunction

    always @(posedge i_clk) begin : driver
        bit hold;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            hold = 1'b0;
            if (s_axis_tvalid && s_axis_tready) begin
                route_q.push_back(route_access(cur.op, cur.addr, cur.data));
                beats_in++;
            end else if (s_axis_tvalid) begin
                hold = 1'b1;
            end
            if (!hold) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (access_q.size() == 0 ||
                             (access_q[0].drain_first && route_q.size() != 0)) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    cur = access_q.pop_front();
                    s_axis_tuser <= cur.op;
                    s_axis_tdata <= {cur.data, cur.addr};
                    s_axis_tvalid <= 1'b1;
                    if (idle_on() && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 17);
                end
            end
        end
    end

    always @(posedge i_clk) begin : sink
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_left > 0) begin
                hold_left--;
            end else if (!long_hold_done && beats_out >= LONG_HOLD_AT) begin
                hold_left = LONG_HOLD_LEN;
                long_hold_done = 1'b1;
            end else if (snk_gap > 0) begin
                snk_gap--;
            end else if (idle_on() && $urandom_range(0, 5) == 0) begin
                snk_gap = $urandom_range(1, 17);
            end
            m_axis_tready <= (hold_left == 0 && snk_gap == 0);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.action        = t_action'(m_axis_tuser);
            got.flash_address = m_axis_tdata[22:0];
            got.scc_offset    = m_axis_tdata[30:23];
            got.psg_register  = m_axis_tdata[34:31];
            got.data_out      = m_axis_tdata[42:35];
            got.scc_plus_mode = m_axis_tdata[43];
            beats_out <= beats_out + 1;
            act_seen[int'(got.action)]++;
            if (route_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] unexpected beat: tuser=%h tdata=%h", $realtime,
                             m_axis_tuser, m_axis_tdata);
            end else begin
                want = route_q.pop_front();
                if (got.action !== want.action || got.flash_address !== want.flash_address ||
                    got.scc_offset !== want.scc_offset ||
                    got.psg_register !== want.psg_register ||
                    got.data_out !== want.data_out ||
                    got.scc_plus_mode !== want.scc_plus_mode ||
                    m_axis_tdata[M_TDATA_W-1:44] !== '0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("[%0t] beat %0d mismatch", $realtime, beats_out);
                        $display("  exp act=%0d fa=%h scc=%h psg=%h dout=%h plus=%b",
                                 want.action, want.flash_address, want.scc_offset,
                                 want.psg_register, want.data_out, want.scc_plus_mode);
                        $display("  got act=%0d fa=%h scc=%h psg=%h dout=%h plus=%b pad=%h",
                                 got.action, got.flash_address, got.scc_offset,
                                 got.psg_register, got.data_out, got.scc_plus_mode,
                                 m_axis_tdata[M_TDATA_W-1:44]);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt,
                     route_q.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin : main
        bus_access_t a;
        for (int i = 0; i < NUM_BANKS; i++) bank_reg[i] = BYTE_W'(i);
        block_reg = '0;
        mode_reg  = '0;
        flash_we  = 1'b0;
        psg_latch = '0;

        add_access(OP_MEM_READ,  16'h0000, 8'h00);
        add_access(OP_MEM_READ,  16'hFFFF, 8'hFF);
        add_access(OP_MEM_READ,  WIN_LO,   8'h5A);
        add_access(OP_MEM_READ,  WIN_HI,   8'h00);
        add_access(OP_MEM_WRITE, 16'h0000, 8'hFF);
        add_access(OP_MEM_WRITE, 16'hC000, 8'h12);
        add_access(OP_IO_WRITE,  {8'hFF, PORT_PSG_INDEX}, 8'hFF);
        add_access(OP_IO_WRITE,  {8'h00, PORT_PSG_DATA},  8'hA5);
        add_access(OP_IO_WRITE,  {8'h00, PORT_BLOCK},     8'hFF);
        add_access(OP_IO_WRITE,  16'h0012, 8'h77);
        add_access(OP_RSVD,      16'hFFFF, 8'hFF);
        add_access(OP_MEM_WRITE, 16'h9000, 8'h3F);
        add_access(OP_MEM_READ,  SCC_LO,   8'h00);
        add_access(OP_MEM_READ,  16'h9900, 8'h00);
        add_access(OP_MEM_WRITE, 16'h9FFD, 8'h81);
        add_access(OP_MEM_READ,  SCC_END,  8'h00);
        add_access(OP_MEM_WRITE, WE_REG_ADDR, WE_KEY);
        add_access(OP_MEM_WRITE, 16'h5000, 8'hFF);
        add_access(OP_MEM_WRITE, WE_REG_ADDR, 8'h51);
        add_access(OP_MEM_WRITE, 16'hBFFE, 8'h20);
        add_access(OP_MEM_WRITE, 16'hB000, 8'h80);
        add_access(OP_MEM_READ,  SCCP_LO,  8'h00);
        add_access(OP_MEM_WRITE, 16'hBFFD, 8'h3C);
        add_access(OP_MEM_READ,  SCC_LO,   8'h00);
        add_access(OP_MEM_WRITE, 16'hBFFF, 8'h10);
        add_access(OP_MEM_READ,  SCCP_LO,  8'h00);
        add_access(OP_MEM_WRITE, 16'hBFFE, 8'h00);
        for (int i = 0; i < RANDOM_ACCESSES; i++) begin
            a = random_access();
            a.drain_first = (i == DRAIN_AT);
            access_q.push_back(a);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (access_q.size() != 0 || s_axis_tvalid || route_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("sent %0d accesses, checked %0d routing beats, %0d errors",
                 beats_in, beats_out, errors);
        $display("actions: none=%0d unmapped=%0d flash rd/wr=%0d/%0d scc rd/wr=%0d/%0d psg=%0d",
                 act_seen[0], act_seen[1], act_seen[2], act_seen[3], act_seen[4],
                 act_seen[5], act_seen[6]);
        if (errors == 0 && route_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
